// ===== rtl/clfte_pkg.sv =====
// Shared codes, command and status types and lookup functions for the timestamp parser.
package clfte_pkg;

  // Parser phases
  localparam logic [3:0] PH_DAY   = 4'd0;
  localparam logic [3:0] PH_SEP1  = 4'd1;
  localparam logic [3:0] PH_MON0  = 4'd2;
  localparam logic [3:0] PH_MON1  = 4'd3;
  localparam logic [3:0] PH_MON2  = 4'd4;
  localparam logic [3:0] PH_SEP2  = 4'd5;
  localparam logic [3:0] PH_YEAR  = 4'd6;
  localparam logic [3:0] PH_SEP3  = 4'd7;
  localparam logic [3:0] PH_HOUR  = 4'd8;
  localparam logic [3:0] PH_SEP4  = 4'd9;
  localparam logic [3:0] PH_MIN   = 4'd10;
  localparam logic [3:0] PH_SEP5  = 4'd11;
  localparam logic [3:0] PH_SEC   = 4'd12;
  localparam logic [3:0] PH_ZSIGN = 4'd13;
  localparam logic [3:0] PH_ZDIG  = 4'd14;
  localparam logic [3:0] PH_DONE  = 4'd15;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;

  // Last count of the epoch pipeline wait: eight register levels behind the fields
  localparam logic [3:0] CALC_LAST = 4'd8;

  typedef struct packed {
    logic       clear;
    logic       num_en;
    logic [3:0] num_sel;
    logic       mon_shift;
    logic       mon_set;
    logic       zsign_en;
    logic       zone_neg;
    logic       zhr_en;
    logic       zmin_en;
    logic       out_load;
    logic       out_ok;
  } cmd_t;

  typedef struct packed {
    logic month_hit;
  } stat_t;

  // Month number 1..12 for an exact three-letter name, 0 otherwise
  function automatic logic [3:0] month_code(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [3:0] code;
    code = 4'd0;
    case ({a, b, c})
      "Jan": code = 4'd1;
      "Feb": code = 4'd2;
      "Mar": code = 4'd3;
      "Apr": code = 4'd4;
      "May": code = 4'd5;
      "Jun": code = 4'd6;
      "Jul": code = 4'd7;
      "Aug": code = 4'd8;
      "Sep": code = 4'd9;
      "Oct": code = 4'd10;
      "Nov": code = 4'd11;
      "Dec": code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  // Days from March 1 to the first of month m, in a March-based year
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd13:   d = 9'd306;
      4'd14:   d = 9'd337;
      4'd15:   d = 9'd0;
      default: d = 9'd275;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/clf_timestamp_to_epoch_parser.sv =====
// Top level of the log timestamp parser: byte-serial parser with epoch arithmetic behind it.
// Result: after the edge that accepts the final byte, the input stalls while the 8-level
//   epoch pipeline settles on the held fields; the result is then loaded, later if the
//   previous result is still stalled at the output.
// Throughput: one byte per cycle while parsing; the next timestamp waits for the result.
// Reset: synchronous rst clears the parser phase, fields, fault flag and output valid.
module clf_timestamp_to_epoch_parser import clfte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  input  logic               final_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               parsed_ok,
  output logic signed [58:0] epoch_micros
);

  cmd_t  cmd;
  stat_t stat;

  // Controller: parse sequencing and handshakes
  clfte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Datapath: fields and epoch arithmetic
  clfte_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .cmd          (cmd),
    .stat         (stat),
    .parsed_ok    (parsed_ok),
    .epoch_micros (epoch_micros)
  );

endmodule

// ===== rtl/clfte_dpath.sv =====
// Field registers, month lookup and the pipelined epoch arithmetic of the timestamp parser.
module clfte_dpath import clfte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         text_byte,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               parsed_ok,
  output logic signed [58:0] epoch_micros
);

  localparam logic [12:0] EraRecip   = 13'd5243;    // 2^21 / 400, rounded up
  localparam logic [17:0] EraDays    = 18'd146097;
  localparam logic signed [23:0] DayBias = 24'sd865565;  // 719468 + 146097
  localparam logic signed [17:0] DaySecs = 18'sd86400;
  localparam logic signed [20:0] Micros  = 21'sd1000000;
  localparam logic [19:0] MicrosU    = 20'd1000000;

  logic [6:0]  day_value;
  logic [15:0] month_letters;
  logic [3:0]  month_number;
  logic [13:0] year_value;
  logic [6:0]  hour_value;
  logic [6:0]  minute_value;
  logic [6:0]  second_value;
  logic        zone_negative;
  logic [6:0]  zone_hours;
  logic [6:0]  zone_minutes;

  logic [3:0]  digit;
  logic [3:0]  month_hit_code;

  // epoch pipeline registers
  logic [14:0]        yy;
  logic [4:0]         era;
  logic [8:0]         doy_base;
  logic [27:0]        era_mul;
  logic [8:0]         yoe;
  logic [21:0]        era_days;
  logic signed [10:0] doy;
  logic [17:0]        y365;
  logic [6:0]         y4;
  logic [1:0]         y100;
  logic [13:0]        y41;
  logic [21:0]        era_days3;
  logic signed [10:0] doy3;
  logic signed [23:0] days;
  logic signed [39:0] day_secs;
  logic [18:0]        tod;
  logic [18:0]        zone;
  logic               zone_neg5;
  logic signed [39:0] secs;
  logic signed [19:0] secs_hi;
  logic [39:0]        prod_lo;
  logic signed [39:0] prod_hi;
  logic [58:0]        micros;

  assign digit = text_byte[3:0];
  assign month_hit_code = month_code(month_letters[15:8], month_letters[7:0], text_byte);
  assign stat.month_hit = (month_hit_code != 4'd0);

  // Accumulate digits, month letters and zone fields; clear when a result is issued
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      day_value     <= '0;
      month_letters <= '0;
      month_number  <= '0;
      year_value    <= '0;
      hour_value    <= '0;
      minute_value  <= '0;
      second_value  <= '0;
      zone_negative <= 1'b0;
      zone_hours    <= '0;
      zone_minutes  <= '0;
    end else begin
      if (cmd.num_en) begin
        unique case (cmd.num_sel) inside
          PH_DAY:  day_value    <= 7'(day_value * 7'd10 + 7'(digit));
          PH_YEAR: year_value   <= 14'(year_value * 14'd10 + 14'(digit));
          PH_HOUR: hour_value   <= 7'(hour_value * 7'd10 + 7'(digit));
          PH_MIN:  minute_value <= 7'(minute_value * 7'd10 + 7'(digit));
          default: second_value <= 7'(second_value * 7'd10 + 7'(digit));
        endcase
      end
      if (cmd.mon_shift) month_letters <= {month_letters[7:0], text_byte};
      if (cmd.mon_set) month_number <= month_hit_code;
      if (cmd.zsign_en) zone_negative <= cmd.zone_neg;
      if (cmd.zhr_en) zone_hours <= 7'(zone_hours * 7'd10 + 7'(digit));
      if (cmd.zmin_en) zone_minutes <= 7'(zone_minutes * 7'd10 + 7'(digit));
    end
  end

  assign era_mul = yy * EraRecip;
  assign y41     = yoe * 6'd41;
  assign secs_hi = secs[39:20];

  // Epoch pipeline: fields are held steady while it settles
  always_ff @(posedge clk) begin
    // shift the year to March and split into 400-year eras
    yy       <= 15'({1'b0, year_value} + 15'd400 -
                    ((month_number == 4'd1 || month_number == 4'd2) ? 15'd1 : 15'd0));
    doy_base <= month_days(month_number);
    era      <= era_mul[25:21];
    // year of era, era day offset, day of year
    yoe      <= 9'(yy - 15'(era * 9'd400));
    era_days <= 22'(era * EraDays);
    doy      <= $signed({2'b00, doy_base}) + $signed({4'b0000, day_value}) - 11'sd1;
    // leap-year terms
    y365      <= 18'(yoe * 9'd365);
    y4        <= yoe[8:2];
    y100      <= y41[13:12];
    era_days3 <= era_days;
    doy3      <= doy;
    // day count since 1970
    days <= $signed({2'b00, era_days3}) + $signed({6'b000000, y365}) +
            $signed({17'b0, y4}) - $signed({22'b0, y100}) + doy3 - DayBias;
    // seconds of the day count, time of day and zone offset
    day_secs  <= days * DaySecs;
    tod       <= 19'(hour_value * 12'd3600 + minute_value * 6'd60 + 19'(second_value));
    zone      <= 19'(zone_hours * 12'd3600 + zone_minutes * 6'd60);
    zone_neg5 <= zone_negative;
    // apply the zone
    secs <= zone_neg5 ? day_secs + $signed({1'b0, tod}) + $signed({1'b0, zone})
                      : day_secs + $signed({1'b0, tod}) - $signed({1'b0, zone});
    // scale to microseconds in two halves
    prod_lo <= secs[19:0] * MicrosU;
    prod_hi <= secs_hi * Micros;
  end

  assign micros = {prod_hi[38:0], 20'b0} + {19'b0, prod_lo};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      parsed_ok    <= cmd.out_ok;
      epoch_micros <= cmd.out_ok ? $signed(micros) : '0;
    end
  end

endmodule

// ===== rtl/clfte_ctrl.sv =====
// Parser state machine, epoch wait sequencing and output handshake of the timestamp parser.
module clfte_ctrl import clfte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd,
  input  stat_t      stat
);

  localparam logic ST_PARSE = 1'b0;
  localparam logic ST_CALC  = 1'b1;

  logic       state, state_next;
  logic [3:0] calc_cnt, calc_cnt_next;
  logic [3:0] phase, phase_next;
  logic [2:0] digit_count, digit_count_next;
  logic       fault_seen, fault_next;
  logic       out_valid_next;

  logic       accept;
  logic       is_dig;
  logic       is_blank;
  logic       is_num;
  logic [2:0] num_limit;
  logic [3:0] ph_eval;
  logic       run_tok;

  assign in_stall = (state == ST_CALC);
  assign accept   = in_valid && !in_stall;

  // Classify the incoming character
  assign is_dig   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_blank = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign is_num   = (phase == PH_DAY) || (phase == PH_YEAR) || (phase == PH_HOUR) ||
                    (phase == PH_MIN) || (phase == PH_SEC);
  assign num_limit = (phase == PH_YEAR) ? 3'd4 : 3'd2;

  // Next-state logic: parse one item, then wait out the epoch pipeline
  always_comb begin
    cmd              = '0;
    state_next       = state;
    calc_cnt_next    = calc_cnt;
    phase_next       = phase;
    digit_count_next = digit_count;
    fault_next       = fault_seen;
    out_valid_next   = out_valid && out_stall;
    ph_eval          = phase;
    run_tok          = 1'b0;

    unique case (state)
      ST_PARSE: begin
        if (accept && !fault_seen) begin
          // numbers end at the first non-digit, which starts the next token
          if (is_num) begin
            if (is_dig) begin
              if (digit_count >= num_limit) begin
                fault_next = 1'b1;
              end else begin
                cmd.num_en       = 1'b1;
                cmd.num_sel      = phase;
                digit_count_next = 3'(digit_count + 3'd1);
              end
            end else if (digit_count == 3'd0) begin
              if (!is_blank) fault_next = 1'b1;
            end else begin
              digit_count_next = 3'd0;
              ph_eval          = 4'(phase + 4'd1);
              phase_next       = ph_eval;
              run_tok          = 1'b1;
            end
          end else begin
            run_tok = 1'b1;
          end

          if (run_tok) begin
            unique case (ph_eval) inside
              PH_SEP1, PH_SEP2: begin
                if (!is_blank) begin
                  if (text_byte == CH_SLASH) phase_next = 4'(ph_eval + 4'd1);
                  else fault_next = 1'b1;
                end
              end
              PH_SEP3, PH_SEP4, PH_SEP5: begin
                if (!is_blank) begin
                  if (text_byte == CH_COLON) phase_next = 4'(ph_eval + 4'd1);
                  else fault_next = 1'b1;
                end
              end
              PH_MON0, PH_MON1: begin
                if (!is_blank) begin
                  cmd.mon_shift = 1'b1;
                  phase_next    = 4'(ph_eval + 4'd1);
                end
              end
              PH_MON2: begin
                if (!is_blank) begin
                  if (stat.month_hit) begin
                    cmd.mon_set = 1'b1;
                    phase_next  = PH_SEP2;
                  end else begin
                    fault_next = 1'b1;
                  end
                end
              end
              PH_ZSIGN: begin
                if (!is_blank) begin
                  cmd.zsign_en     = 1'b1;
                  cmd.zone_neg     = (text_byte == CH_MINUS);
                  digit_count_next = 3'd0;
                  phase_next       = PH_ZDIG;
                end
              end
              PH_ZDIG: begin
                if (!is_dig) begin
                  fault_next = 1'b1;
                end else begin
                  if (digit_count < 3'd2) cmd.zhr_en = 1'b1;
                  else cmd.zmin_en = 1'b1;
                  if (digit_count == 3'd3) begin
                    digit_count_next = 3'd0;
                    phase_next       = PH_DONE;
                  end else begin
                    digit_count_next = 3'(digit_count + 3'd1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        if (accept && final_byte) begin
          state_next    = ST_CALC;
          calc_cnt_next = 4'd0;
        end
      end

      ST_CALC: begin
        if (calc_cnt != CALC_LAST) begin
          calc_cnt_next = 4'(calc_cnt + 4'd1);
        end else if (!out_valid || !out_stall) begin
          // issue the result and return to the reset state
          cmd.out_load     = 1'b1;
          cmd.out_ok       = !fault_seen && (phase == PH_DONE);
          cmd.clear        = 1'b1;
          out_valid_next   = 1'b1;
          phase_next       = PH_DAY;
          digit_count_next = 3'd0;
          fault_next       = 1'b0;
          state_next       = ST_PARSE;
          calc_cnt_next    = 4'd0;
        end
      end

      default: begin
        state_next = ST_PARSE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_PARSE;
      calc_cnt    <= '0;
      phase       <= PH_DAY;
      digit_count <= '0;
      fault_seen  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      calc_cnt    <= calc_cnt_next;
      phase       <= phase_next;
      digit_count <= digit_count_next;
      fault_seen  <= fault_next;
      out_valid   <= out_valid_next;
    end
  end

  // A final item starts the epoch wait from its first count
  a_final_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (state == ST_CALC && calc_cnt == 4'd0))
    else $error("final item did not start the epoch wait");

  // The epoch wait is not cut short
  a_calc_full_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && calc_cnt != CALC_LAST) |=> (state == ST_CALC))
    else $error("epoch wait ended early");

  // Issuing a result leaves a valid output and a cleared parser
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && phase == PH_DAY && !fault_seen && digit_count == 3'd0))
    else $error("result issue did not clear the parser");

  // A fault holds until the result is issued
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (fault_seen && !cmd.out_load) |=> fault_seen)
    else $error("fault dropped before the result");

endmodule
